FILE: rtl/dsfp_pkg.sv
package dsfp_pkg;

  localparam int unsigned MaxTokensDef   = 3;
  localparam int unsigned NumberWidthDef = 16;

  localparam int unsigned ChWidth    = 8;
  localparam int unsigned DayWidth   = 5;
  localparam int unsigned MonthWidth = 4;
  localparam int unsigned YearWidth  = 16;
  localparam int unsigned CountWidth = 2;
  localparam int unsigned NumMonths  = 12;
  localparam int unsigned NumLetters = 3;

  localparam logic [31:0]          DayLimit = 32'd31;
  localparam logic [31:0]          YearMax  = 32'h0000_FFFF;
  localparam logic [ChWidth-1:0]   CaseMask = 8'hDF;

  // Month names, upper case, three letters each, January first.
  localparam logic [3*ChWidth-1:0] MonthNames [NumMonths] = '{
    "JAN", "FEB", "MAR", "APR", "MAY", "JUN",
    "JUL", "AUG", "SEP", "OCT", "NOV", "DEC"
  };

  typedef enum logic [2:0] {
    KIND_NONE    = 3'b001,
    KIND_NUMBER  = 3'b010,
    KIND_LETTERS = 3'b100
  } kind_e;

  typedef struct packed {
    logic [DayWidth-1:0]   day;
    logic [MonthWidth-1:0] month;
    logic [YearWidth-1:0]  year;
    logic [CountWidth-1:0] tokens_found;
    logic                  number_saturated;
  } result_t;

  // Returns 1..12 for a matching letter run of three or more letters, else 0.
  function automatic logic [MonthWidth-1:0] match_month(
    input logic [3*ChWidth-1:0] letters,
    input logic [1:0]           count
  );
    logic [MonthWidth-1:0] m;
    m = '0;
    if (count == 2'd3) begin
      for (int unsigned i = 0; i < NumMonths; i++) begin
        if (letters == MonthNames[i]) begin
          m = MonthWidth'(i + 1);
        end
      end
    end
    return m;
  endfunction

endpackage

FILE: rtl/dsfp_if.sv
interface dsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface dsfp_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [15:0] year;
  logic [1:0]  tokens_found;
  logic        number_saturated;

  modport source (output valid, output day, output month, output year,
                  output tokens_found, output number_saturated, input ready);
  modport sink   (input valid, input day, input month, input year,
                  input tokens_found, input number_saturated, output ready);
endinterface

FILE: rtl/date_string_field_parser.sv
// Date string field parser. Characters arrive one word per cycle with a last
// flag; digit runs become numbers (up to 31 a day, above that a year) and
// letter runs become month numbers; only the first MaxTokens tokens of a string
// count. The block takes one character every clock cycle unless a last
// character is held up: each word is captured in an input register, then a
// single pass through the token logic updates the parser state and, on the
// last character, loads the result register. A result still waiting in the
// output register holds up only a following last character; ordinary
// characters keep flowing.
module date_string_field_parser #(
  parameter int unsigned MaxTokens   = dsfp_pkg::MaxTokensDef,
  parameter int unsigned NumberWidth = dsfp_pkg::NumberWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  dsfp_in_if.sink         in_i,
  dsfp_out_if.source      out_o
);
  import dsfp_pkg::*;

  logic               in_valid_q;
  logic [ChWidth-1:0] in_ch_q;
  logic               in_last_q;
  logic               step;
  result_t            core_result;
  logic               out_valid_q, out_valid_d;
  result_t            result_q;

  // A last word may proceed only when the result register is free or emptying.
  assign step       = in_valid_q && (!in_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_ch_q   <= in_i.ch;
      in_last_q <= in_i.last;
    end
  end

  dsfp_core #(
    .MaxTokens   (MaxTokens),
    .NumberWidth (NumberWidth)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .ch_i     (in_ch_q),
    .last_i   (in_last_q),
    .result_o (core_result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (step && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      result_q <= core_result;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.day              = result_q.day;
  assign out_o.month            = result_q.month;
  assign out_o.year             = result_q.year;
  assign out_o.tokens_found     = result_q.tokens_found;
  assign out_o.number_saturated = result_q.number_saturated;

endmodule

FILE: rtl/dsfp_core.sv
module dsfp_core #(
  parameter int unsigned MaxTokens   = dsfp_pkg::MaxTokensDef,
  parameter int unsigned NumberWidth = dsfp_pkg::NumberWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [dsfp_pkg::ChWidth-1:0]  ch_i,
  input  logic                          last_i,
  output dsfp_pkg::result_t             result_o
);
  import dsfp_pkg::*;

  typedef struct packed {
    logic [DayWidth-1:0]   day;
    logic [MonthWidth-1:0] month;
    logic [YearWidth-1:0]  year;
  } fields_t;

  fields_t                    fields_q, fields_d;
  logic [CountWidth-1:0]      count_q, count_d;
  kind_e                      kind_q, kind_d;
  logic [NumberWidth-1:0]     accum_q, accum_d;
  logic [ChWidth-1:0]         letters_q [NumLetters];
  logic [ChWidth-1:0]         letters_d [NumLetters];
  logic [1:0]                 lcount_q, lcount_d;
  logic                       sat_q, sat_d;

  // Applies the open token to the day, month and year fields.
  function automatic fields_t close_fields(
    input fields_t                f,
    input kind_e                  kind,
    input logic [NumberWidth-1:0] accum,
    input logic [3*ChWidth-1:0]   letters,
    input logic [1:0]             lcount
  );
    fields_t     r;
    logic [31:0] acc32;
    r     = f;
    acc32 = 32'(accum);
    if (kind == KIND_NUMBER) begin
      if (acc32 <= DayLimit) begin
        r.day = acc32[DayWidth-1:0];
      end else if (acc32 > YearMax) begin
        r.year = YearMax[YearWidth-1:0];
      end else begin
        r.year = acc32[YearWidth-1:0];
      end
    end else if (kind == KIND_LETTERS) begin
      r.month = match_month(letters, lcount);
    end
    return r;
  endfunction

  kind_e                  in_kind;
  logic                   is_digit, is_upper, is_lower;
  logic [NumberWidth+3:0] num_next;
  fields_t                fields_mid, fields_out;
  logic [CountWidth-1:0]  count_mid;
  kind_e                  kind_mid;
  logic [NumberWidth-1:0] accum_mid;
  logic [ChWidth-1:0]     letters_mid [NumLetters];
  logic [1:0]             lcount_mid;
  logic                   sat_mid;

  always_comb begin
    is_digit = (ch_i >= "0") && (ch_i <= "9");
    is_upper = (ch_i >= "A") && (ch_i <= "Z");
    is_lower = (ch_i >= "a") && (ch_i <= "z");
    if (is_digit) begin
      in_kind = KIND_NUMBER;
    end else if (is_upper || is_lower) begin
      in_kind = KIND_LETTERS;
    end else begin
      in_kind = KIND_NONE;
    end

    fields_mid  = fields_q;
    count_mid   = count_q;
    kind_mid    = kind_q;
    accum_mid   = accum_q;
    letters_mid = letters_q;
    lcount_mid  = lcount_q;
    sat_mid     = sat_q;

    // A change of character class closes the open token and may open one.
    if (in_kind != kind_q) begin
      fields_mid  = close_fields(fields_q, kind_q, accum_q,
                                 {letters_q[0], letters_q[1], letters_q[2]}, lcount_q);
      kind_mid    = KIND_NONE;
      accum_mid   = '0;
      lcount_mid  = '0;
      letters_mid = '{default: '0};
      if ((in_kind != KIND_NONE) && (count_q < CountWidth'(MaxTokens))) begin
        kind_mid  = in_kind;
        count_mid = count_q + 1'b1;
      end
    end

    num_next = {accum_mid, 3'b000} + {2'b00, accum_mid, 1'b0}
             + (NumberWidth+4)'(ch_i[3:0]);
    if (kind_mid == KIND_NUMBER) begin
      if (num_next[NumberWidth+3:NumberWidth] != '0) begin
        accum_mid = '1;
        sat_mid   = 1'b1;
      end else begin
        accum_mid = num_next[NumberWidth-1:0];
      end
    end else if ((kind_mid == KIND_LETTERS) && (lcount_mid != 2'd3)) begin
      letters_mid[lcount_mid] = ch_i & CaseMask;
      lcount_mid              = lcount_mid + 1'b1;
    end

    fields_out = close_fields(fields_mid, kind_mid, accum_mid,
                              {letters_mid[0], letters_mid[1], letters_mid[2]},
                              lcount_mid);

    result_o.day              = fields_out.day;
    result_o.month            = fields_out.month;
    result_o.year             = fields_out.year;
    result_o.tokens_found     = count_mid;
    result_o.number_saturated = sat_mid;

    fields_d  = fields_q;
    count_d   = count_q;
    kind_d    = kind_q;
    accum_d   = accum_q;
    letters_d = letters_q;
    lcount_d  = lcount_q;
    sat_d     = sat_q;
    if (step_i) begin
      if (last_i) begin
        fields_d  = '0;
        count_d   = '0;
        kind_d    = KIND_NONE;
        accum_d   = '0;
        letters_d = '{default: '0};
        lcount_d  = '0;
        sat_d     = 1'b0;
      end else begin
        fields_d  = fields_mid;
        count_d   = count_mid;
        kind_d    = kind_mid;
        accum_d   = accum_mid;
        letters_d = letters_mid;
        lcount_d  = lcount_mid;
        sat_d     = sat_mid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fields_q  <= '0;
      count_q   <= '0;
      kind_q    <= KIND_NONE;
      accum_q   <= '0;
      letters_q <= '{default: '0};
      lcount_q  <= '0;
      sat_q     <= 1'b0;
    end else begin
      fields_q  <= fields_d;
      count_q   <= count_d;
      kind_q    <= kind_d;
      accum_q   <= accum_d;
      letters_q <= letters_d;
      lcount_q  <= lcount_d;
      sat_q     <= sat_d;
    end
  end

endmodule

FILE: rtl/dsfp_checker.sv
module dsfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [4:0]  day_i,
  input logic [3:0]  month_i,
  input logic [15:0] year_i,
  input logic [1:0]  tokens_found_i
);

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(day_i) && $stable(month_i)
      && $stable(year_i) && $stable(tokens_found_i))
    else $error("result changed while stalled");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> month_i <= 4'd12)
    else $error("month out of range");

  // A year is only ever taken from a number above the day limit.
  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (year_i != 16'd0) |-> year_i > 16'd31)
    else $error("year at or below day limit");

  a_no_tokens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (tokens_found_i == 2'd0) |->
      (day_i == 5'd0) && (month_i == 4'd0) && (year_i == 16'd0))
    else $error("fields set without tokens");

endmodule

bind date_string_field_parser dsfp_checker u_dsfp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .day_i          (out_o.day),
  .month_i        (out_o.month),
  .year_i         (out_o.year),
  .tokens_found_i (out_o.tokens_found)
);

FILE: verif/tb_date_string_field_parser.sv
module tb_date_string_field_parser;
  import dsfp_pkg::*;

  localparam int unsigned TokenLimit  = MaxTokensDef;
  localparam int unsigned DayMax      = 31;
  localparam int unsigned NumberCeil  = (1 << NumberWidthDef) - 1;
  localparam int unsigned RandomChars = 1400;
  localparam int unsigned HoldStart   = 1200;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned ReportMax   = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dsfp_in_if  in_if ();
  dsfp_out_if out_if ();

  date_string_field_parser #(
    .MaxTokens  (TokenLimit),
    .NumberWidth(NumberWidthDef)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  string month_words [12] = '{
    "JANUARY", "FEBRUARY", "MARCH", "APRIL", "MAY", "JUNE",
    "JULY", "AUGUST", "SEPTEMBER", "OCTOBER", "NOVEMBER", "DECEMBER"
  };

  char_word_t  pending_chars[$];
  logic [7:0]  date_text[$];
  result_t     parsed_dates_q[$];

  int unsigned mismatch_count = 0;
  int unsigned dates_checked  = 0;
  int unsigned chars_taken    = 0;
  int unsigned clamped_dates  = 0;
  int unsigned named_months   = 0;
  int unsigned idle_cycles    = 0;
  int unsigned random_chars   = 0;

  // Parser state as seen by the testbench.
  logic [4:0]  held_day;
  logic [3:0]  held_month;
  logic [15:0] held_year;
  int unsigned tokens_opened;
  kind_e       open_kind;
  logic [31:0] field_accum;
  logic [7:0]  letter_buf [3];
  int unsigned letter_total;
  bit          clamped;

  function automatic kind_e char_kind(input logic [7:0] c);
    if (c >= "0" && c <= "9") return KIND_NUMBER;
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) return KIND_LETTERS;
    return KIND_NONE;
  endfunction

  task automatic clear_parser();
    held_day      = '0;
    held_month    = '0;
    held_year     = '0;
    tokens_opened = 0;
    open_kind     = KIND_NONE;
    field_accum   = '0;
    letter_buf    = '{default: '0};
    letter_total  = 0;
    clamped       = 1'b0;
  endtask

  task automatic close_field();
    if (open_kind == KIND_NUMBER) begin
      if (field_accum <= DayMax) begin
        held_day = field_accum[4:0];
      end else begin
        held_year = (field_accum > 32'hFFFF) ? 16'hFFFF : field_accum[15:0];
      end
    end else if (open_kind == KIND_LETTERS) begin
      held_month = '0;
      if (letter_total == 3) begin
        for (int m = 0; m < 12; m++) begin
          if (letter_buf[0] == 8'(month_words[m][0]) &&
              letter_buf[1] == 8'(month_words[m][1]) &&
              letter_buf[2] == 8'(month_words[m][2])) begin
            held_month = 4'(m + 1);
          end
        end
      end
    end
    open_kind    = KIND_NONE;
    field_accum  = '0;
    letter_buf   = '{default: '0};
    letter_total = 0;
  endtask

  task automatic parse_date_char(input logic [7:0] c, input logic fin,
                                 output bit done, output result_t r);
    kind_e       k;
    logic [31:0] next_val;
    k = char_kind(c);
    // A change of character class ends the open token; a new token opens only
    // while the string still has token slots left.
    if (k != open_kind) begin
      close_field();
      if (k != KIND_NONE && tokens_opened < TokenLimit) begin
        open_kind = k;
        tokens_opened++;
      end
    end
    if (open_kind == KIND_NUMBER) begin
      next_val = field_accum * 10 + 32'(c - 8'd48);
      if (next_val > NumberCeil) begin
        next_val = NumberCeil;
        clamped  = 1'b1;
      end
      field_accum = next_val;
    end else if (open_kind == KIND_LETTERS && letter_total < 3) begin
      letter_buf[letter_total] = (c >= "a") ? c - 8'd32 : c;
      letter_total++;
    end
    done = fin;
    r    = '0;
    if (fin) begin
      close_field();
      r.day              = held_day;
      r.month            = held_month;
      r.year             = held_year;
      r.tokens_found     = 2'(tokens_opened);
      r.number_saturated = clamped;
      clear_parser();
    end
  endtask

  // Stimulus helpers: build one string in date_text, then queue it.
  task automatic queue_text();
    char_word_t w;
    for (int i = 0; i < date_text.size(); i++) begin
      w.ch   = date_text[i];
      w.last = (i == date_text.size() - 1);
      pending_chars.push_back(w);
    end
    date_text.delete();
  endtask

  task automatic queue_literal(input string s);
    for (int i = 0; i < s.len(); i++) date_text.push_back(8'(s[i]));
    queue_text();
  endtask

  task automatic put_sep();
    int unsigned n;
    logic [7:0]  c;
    n = $urandom_range(1, 2);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: c = " ";
        1: c = ",";
        2: c = "-";
        3: c = "/";
        default: begin
          do c = 8'($urandom_range(0, 255)); while (char_kind(c) != KIND_NONE);
        end
      endcase
      date_text.push_back(c);
    end
  endtask

  task automatic put_number(input int unsigned v, input int unsigned pad);
    logic [7:0] digits[$];
    do begin
      digits.push_front(8'(48 + v % 10));
      v = v / 10;
    end while (v != 0);
    while (digits.size() < pad) digits.push_front("0");
    foreach (digits[i]) date_text.push_back(digits[i]);
  endtask

  task automatic put_digits(input int unsigned n);
    repeat (n) date_text.push_back(8'(48 + $urandom_range(0, 9)));
  endtask

  task automatic put_month();
    int unsigned m;
    int unsigned style;
    int unsigned len;
    logic [7:0]  c;
    m     = $urandom_range(0, 11);
    style = $urandom_range(0, 7);
    if (style <= 3)      len = 3;
    else if (style <= 5) len = month_words[m].len();
    else if (style == 6) len = $urandom_range(1, 2);
    else                 len = $urandom_range(3, 5);
    for (int i = 0; i < len; i++) begin
      c = (style == 7) ? 8'(65 + $urandom_range(0, 25)) : 8'(month_words[m][i]);
      if ($urandom_range(0, 1) != 0) c = c | 8'h20;
      date_text.push_back(c);
    end
  endtask

  task automatic put_year();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: put_number($urandom_range(1900, 2099), 0);
      6, 7:             put_number($urandom_range(32, 65535), 0);
      8:                put_number($urandom_range(65536, 999999), 0);
      default:          put_number($urandom_range(0, 31), $urandom_range(0, 4));
    endcase
  endtask

  task automatic put_noise();
    int unsigned n;
    n = $urandom_range(1, 10);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0:       date_text.push_back(8'(48 + $urandom_range(0, 9)));
        1:       date_text.push_back(8'(65 + $urandom_range(0, 25)) |
                                     ($urandom_range(0, 1) ? 8'h20 : 8'h00));
        default: date_text.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Sender: bursts of words separated by random gaps.
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.ch    <= '0;
      in_if.last  <= 1'b0;
      burst_left  <= 0;
      gap_left    <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left != 0) begin
        gap_left    <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (pending_chars.size() != 0) begin
        in_if.ch    <= pending_chars[0].ch;
        in_if.last  <= pending_chars[0].last;
        in_if.valid <= 1'b1;
        void'(pending_chars.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall mode re-chosen whenever rx_cycle[6:0] is zero, plus one long hold-off.
  int unsigned rx_cycle;
  int unsigned rx_mode;
  int unsigned hold_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_cycle     <= 0;
      rx_mode      <= 0;
      hold_left    <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle[6:0] == 7'd0) rx_mode <= $urandom_range(0, 3);
      if (rx_cycle == HoldStart) begin
        hold_left    <= HoldCycles;
        out_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= ($urandom_range(0, 1) != 0);
          2:       out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= (rx_cycle[2:0] != 3'd5) && (rx_cycle[2:0] != 3'd6);
        endcase
      end
    end
  end

  // Results are checked before the word accepted at the same edge is parsed.
  always @(posedge clk_i) begin : check_dates
    result_t got;
    result_t want;
    result_t fresh;
    bit      fin_seen;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.day, out_if.month, out_if.year, out_if.tokens_found,
               out_if.number_saturated};
        if (parsed_dates_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportMax)
            $display("unexpected result: day %0d month %0d year %0d tokens %0d sat %0b",
                     got.day, got.month, got.year, got.tokens_found,
                     got.number_saturated);
        end else begin
          want = parsed_dates_q.pop_front();
          dates_checked++;
          if (got.day !== want.day || got.month !== want.month ||
              got.year !== want.year || got.tokens_found !== want.tokens_found ||
              got.number_saturated !== want.number_saturated) begin
            mismatch_count++;
            if (mismatch_count <= ReportMax)
              $display({"date %0d mismatch: expected day %0d month %0d year %0d ",
                        "tokens %0d sat %0b, got day %0d month %0d year %0d ",
                        "tokens %0d sat %0b"}, dates_checked,
                       want.day, want.month, want.year, want.tokens_found,
                       want.number_saturated, got.day, got.month, got.year,
                       got.tokens_found, got.number_saturated);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        chars_taken++;
        parse_date_char(in_if.ch, in_if.last, fin_seen, fresh);
        if (fin_seen) begin
          parsed_dates_q.push_back(fresh);
          if (fresh.number_saturated) clamped_dates++;
          if (fresh.month != 0) named_months++;
        end
      end
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("timeout: no word moved for %0d cycles, %0d dates still pending",
             IdleLimit, parsed_dates_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : run_test
    int unsigned fmt;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.ch     = '0;
    in_if.last   = 1'b0;
    out_if.ready = 1'b0;
    clear_parser();

    // Directed strings: lone separators at both byte extremes, adjacent
    // token kinds with a clamped year, a long letter run with an ignored
    // fourth token that would clamp, and a short letter run.
    date_text.push_back(8'h00);
    queue_text();
    date_text.push_back(8'hFF);
    queue_text();
    queue_literal("3dec99999");
    queue_literal("Octo,5,1,99999");
    queue_literal("mA");

    while (random_chars < RandomChars) begin
      fmt = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) put_sep();
      case (fmt)
        0, 1: begin
          put_number($urandom_range(1, 31), $urandom_range(0, 2));
          put_sep(); put_month(); put_sep(); put_year();
        end
        2: begin
          put_month(); put_sep();
          put_number($urandom_range(1, 31), 0); put_sep(); put_year();
        end
        3: begin
          put_year(); put_sep();
          put_number($urandom_range(1, 12), 2); put_sep();
          put_number($urandom_range(1, 31), 2);
        end
        4: begin
          put_number($urandom_range(0, 31), 0); put_sep(); put_month();
          put_sep(); put_year(); put_sep();
          if ($urandom_range(0, 1) != 0) put_digits($urandom_range(5, 9));
          else put_month();
        end
        5: begin
          // Token kinds back to back with no separator.
          if ($urandom_range(0, 1) != 0) begin
            put_month(); put_number($urandom_range(0, 31), 0); put_sep(); put_year();
          end else begin
            put_number($urandom_range(0, 31), 0); put_month(); put_year();
          end
        end
        6: begin
          if ($urandom_range(0, 1) != 0) put_digits($urandom_range(1, 12));
          else put_month();
        end
        7: put_sep();
        8: begin
          repeat ($urandom_range(4, 6)) begin
            if ($urandom_range(0, 1) != 0) put_digits($urandom_range(1, 7));
            else put_month();
            put_sep();
          end
        end
        default: put_noise();
      endcase
      if ($urandom_range(0, 3) == 0) put_sep();
      random_chars += date_text.size();
      queue_text();
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_chars.size() != 0 || in_if.valid || parsed_dates_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Streamed %0d characters and checked %0d parsed dates,", chars_taken,
             dates_checked);
    $display("%0d with a clamped number and %0d with a named month; output held off %0d cycles.",
             clamped_dates, named_months, HoldCycles);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatching results", mismatch_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
